// ----- hdl/cfir_pkg.sv -----
// Shared types and constants for the complex FIR filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package cfir_pkg;

  localparam int unsigned IDX_W   = 5;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned OP_W    = 2;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  // broadcast to every tap cell
  typedef struct packed {
    logic             shift;
    logic             clear;
    logic             load;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/cfir_cell.sv -----
// One tap of the complex FIR chain: delay sample, coefficient, complex product
// and a registered partial sum passed on to the next cell. Uses cfir_pkg.
`default_nettype none

module cfir_cell #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned INDEX        = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cfir_pkg::cmd_t              cmd,
  input  wire logic [SAMPLE_WIDTH-1:0]     din_re,
  input  wire logic [SAMPLE_WIDTH-1:0]     din_im,
  input  wire logic [SAMPLE_WIDTH-1:0]     ld_re,
  input  wire logic [SAMPLE_WIDTH-1:0]     ld_im,
  input  wire logic [cfir_pkg::ACC_W-1:0]  psum_in_re,
  input  wire logic [cfir_pkg::ACC_W-1:0]  psum_in_im,
  output logic      [SAMPLE_WIDTH-1:0]     dout_re,
  output logic      [SAMPLE_WIDTH-1:0]     dout_im,
  output logic      [cfir_pkg::ACC_W-1:0]  psum_out_re,
  output logic      [cfir_pkg::ACC_W-1:0]  psum_out_im
);
  import cfir_pkg::*;

  localparam int unsigned PW = 2 * SAMPLE_WIDTH;

  logic signed [SAMPLE_WIDTH-1:0] coef_re;
  logic signed [SAMPLE_WIDTH-1:0] coef_im;
  logic signed [PW-1:0]           p_rr;
  logic signed [PW-1:0]           p_ii;
  logic signed [PW-1:0]           p_ri;
  logic signed [PW-1:0]           p_ir;
  logic signed [63:0]             w_rr;
  logic signed [63:0]             w_ii;
  logic signed [63:0]             w_ri;
  logic signed [63:0]             w_ir;
  logic                           hit;

  assign hit = cmd.load && (32'(cmd.idx) == INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_re <= '0;
      dout_im <= '0;
    end else if (cmd.clear) begin
      dout_re <= '0;
      dout_im <= '0;
    end else if (cmd.shift) begin
      dout_re <= din_re;
      dout_im <= din_im;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      coef_re <= ld_re;
      coef_im <= ld_im;
    end
  end

  always_ff @(posedge clk) begin
    p_rr <= $signed(dout_re) * coef_re;
    p_ii <= $signed(dout_im) * coef_im;
    p_ri <= $signed(dout_re) * coef_im;
    p_ir <= coef_re * $signed(dout_im);
  end

  assign w_rr = 64'(p_rr);
  assign w_ii = 64'(p_ii);
  assign w_ri = 64'(p_ri);
  assign w_ir = 64'(p_ir);

  // sums wrap modulo 2^ACC_W
  always_ff @(posedge clk) begin
    psum_out_re <= psum_in_re + w_rr[ACC_W-1:0] - w_ii[ACC_W-1:0];
    psum_out_im <= psum_in_im + w_ri[ACC_W-1:0] + w_ir[ACC_W-1:0];
  end

endmodule

`default_nettype wire

// ----- hdl/cfir_ctrl.sv -----
// Sequencer for the complex FIR: input handshake, op decode, settle counter
// for the partial-sum chain and the output valid flag. Uses cfir_pkg.
`default_nettype none

module cfir_ctrl #(
  parameter int unsigned TAPS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [cfir_pkg::OP_W-1:0]  op,
  input  wire logic [cfir_pkg::IDX_W-1:0] tap_index,
  input  wire logic                      out_ready,
  output logic                           in_ready,
  output logic                           out_valid,
  output cfir_pkg::cmd_t                 cmd,
  output cfir_pkg::sts_t                 sts
);
  import cfir_pkg::*;

  localparam int unsigned CNT_W = $clog2(TAPS + 2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS + 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && op == OP_SAMPLE) state_next = ST_CALC;
      ST_CALC: if (cnt == CNT_LAST && out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    sts      = '0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_CALC: begin
        sts.busy = 1'b1;
        sts.done = (cnt == CNT_LAST) && out_free;
      end
      default: in_ready = 1'b0;
    endcase
    cmd.shift = accept && (op == OP_SAMPLE);
    cmd.clear = accept && (op == OP_CLEAR);
    cmd.load  = accept && (op == OP_LOAD);
    cmd.idx   = tap_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (cnt != CNT_LAST) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sts.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/complex_fir_filter_unit.sv -----
// Complex FIR filter top level: a chain of TAPS tap cells and its sequencer.
// Depends on cfir_pkg, cfir_cell and cfir_ctrl.
//
// Input stream (s_axis): tuser carries the op (load, sample, clear); tdata
// carries tap index, real and imaginary value. Load writes one coefficient,
// clear zeroes the delay line; neither of them yields an output word.
// A sample word shifts the delay line and yields one output word (m_axis)
// with the 40-bit real and imaginary sums.
// A sample's result reaches the output register after the product
// registers and then the partial sum register of each cell down the chain.
// The input is not ready during that time, so a new sample is taken only
// once the last one's sum is finished; load and clear words are taken
// every cycle while idle.
// The output register holds the result while the receiver stalls; the
// block still takes load, clear and the next sample meanwhile, and waits at
// the end of that calculation until the register is free.
// Reset (rst, synchronous) zeroes the delay line and empties the output;
// coefficients must be loaded before the first sample.
`default_nettype none

module complex_fir_filter_unit #(
  parameter int unsigned TAPS         = 32,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // tap_index[4:0], real_value[20:5], imag_value[36:21]
  input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata   // out_real[39:0], out_imag[79:40]
);
  import cfir_pkg::*;

  cmd_t                    cmd;
  sts_t                    sts;
  logic [31:0]             re_ext;
  logic [31:0]             im_ext;
  logic [SAMPLE_WIDTH-1:0] smp_re;
  logic [SAMPLE_WIDTH-1:0] smp_im;
  logic [SAMPLE_WIDTH-1:0] dly_re [TAPS];
  logic [SAMPLE_WIDTH-1:0] dly_im [TAPS];
  logic [ACC_W-1:0]        psum_re [TAPS+1];
  logic [ACC_W-1:0]        psum_im [TAPS+1];
  logic [ACC_W-1:0]        out_re;
  logic [ACC_W-1:0]        out_im;

  assign re_ext = 32'(s_axis_tdata[20:5]);
  assign im_ext = 32'(s_axis_tdata[36:21]);
  assign smp_re = re_ext[SAMPLE_WIDTH-1:0];
  assign smp_im = im_ext[SAMPLE_WIDTH-1:0];

  assign psum_re[0] = '0;
  assign psum_im[0] = '0;

  cfir_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .op        (s_axis_tuser),
    .tap_index (s_axis_tdata[4:0]),
    .out_ready (m_axis_tready),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .cmd       (cmd),
    .sts       (sts)
  );

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    logic [SAMPLE_WIDTH-1:0] din_re;
    logic [SAMPLE_WIDTH-1:0] din_im;
    if (k == 0) begin : g_head
      assign din_re = smp_re;
      assign din_im = smp_im;
    end else begin : g_body
      assign din_re = dly_re[k-1];
      assign din_im = dly_im[k-1];
    end
    cfir_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .INDEX        (k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .din_re      (din_re),
      .din_im      (din_im),
      .ld_re       (smp_re),
      .ld_im       (smp_im),
      .psum_in_re  (psum_re[k]),
      .psum_in_im  (psum_im[k]),
      .dout_re     (dly_re[k]),
      .dout_im     (dly_im[k]),
      .psum_out_re (psum_re[k+1]),
      .psum_out_im (psum_im[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (sts.done) begin
      out_re <= psum_re[TAPS];
      out_im <= psum_im[TAPS];
    end
  end

  assign m_axis_tdata = {out_im, out_re};

  a_sample_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SAMPLE) |=> !s_axis_tready)
    else $error("input ready while a sample is being summed");

  a_done_gives_word: assert property (@(posedge clk) disable iff (rst)
    sts.done |=> m_axis_tvalid)
    else $error("finished sum did not reach the output");

  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> (sts.busy && !s_axis_tready))
    else $error("result taken while idle");

endmodule

`default_nettype wire
